// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, phase codes and request codes for the I2C master bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    localparam int TPU_W   = 10;
    localparam int TMO_W   = 8;
    localparam int DLY_W   = 12;
    localparam int PHASE_W = 5;

    // request codes
    localparam logic [2:0] REQ_NONE  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    // configuration register indexes
    localparam logic CFG_TPU = 1'b0;
    localparam logic CFG_TMO = 1'b1;

    // bus phases
    localparam logic [PHASE_W-1:0] PH_IDLE     = 5'd0;
    localparam logic [PHASE_W-1:0] PH_ST_A     = 5'd1;
    localparam logic [PHASE_W-1:0] PH_ST_B     = 5'd2;
    localparam logic [PHASE_W-1:0] PH_ST_C     = 5'd3;
    localparam logic [PHASE_W-1:0] PH_SP_A     = 5'd4;
    localparam logic [PHASE_W-1:0] PH_SP_B     = 5'd5;
    localparam logic [PHASE_W-1:0] PH_SP_C     = 5'd6;
    localparam logic [PHASE_W-1:0] PH_WR_LEAD  = 5'd7;
    localparam logic [PHASE_W-1:0] PH_WR_SETUP = 5'd8;
    localparam logic [PHASE_W-1:0] PH_WR_HIGH  = 5'd9;
    localparam logic [PHASE_W-1:0] PH_AK_REL   = 5'd10;
    localparam logic [PHASE_W-1:0] PH_AK_HIGH  = 5'd11;
    localparam logic [PHASE_W-1:0] PH_AK_POLL  = 5'd12;
    localparam logic [PHASE_W-1:0] PH_AK_END   = 5'd13;
    localparam logic [PHASE_W-1:0] PH_RD_LOW   = 5'd14;
    localparam logic [PHASE_W-1:0] PH_RD_SAMP  = 5'd15;
    localparam logic [PHASE_W-1:0] PH_RD_HIGH  = 5'd16;
    localparam logic [PHASE_W-1:0] PH_AC_A     = 5'd17;
    localparam logic [PHASE_W-1:0] PH_AC_B     = 5'd18;
    localparam logic [PHASE_W-1:0] PH_AC_C     = 5'd19;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [DLY_W-1:0]   delay_count;
        logic [3:0]         bit_index;
        logic [7:0]         shift_data;
        logic [7:0]         poll_count;
        logic               ack_choice;
        logic               scl;
        logic               sda;
        logic               drive;
        logic               error_flag;
        logic [7:0]         rx_hold;
    } t_state;

    typedef struct packed {
        logic [TPU_W-1:0] ticks_per_us;
        logic [TMO_W-1:0] ack_timeout;
    } t_cfg;

    // Ticks in a wait of (1 << log2_units) microsecond units for log2_units up to 2, never zero.
    function automatic logic [DLY_W-1:0] unit_ticks(input logic [TPU_W-1:0] tpu,
                                                    input logic [1:0] log2_units);
        logic [DLY_W-1:0] t;
        case (log2_units)
            2'd0:    t = {2'b00, tpu};
            2'd1:    t = {1'b0, tpu, 1'b0};
            default: t = {tpu, 2'b00};
        endcase
        if (t == '0) begin
            t = DLY_W'(1);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/i2c_master_bit_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master waveform engine: one input transfer is one bus tick.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-----------------------------------
//  s       | in  | i_s_tvalid/o_s_tready  | tick: request, tx byte, ack, SDA
//  m       | out | o_m_tvalid/i_m_tready  | pins, busy, done, rx byte, error
//  cfg     | in  | i_cfg_we               | ticks_per_us, ack_timeout
//
//  The state update is a single combinational pass from the state
//  registers into the state and result registers, so a tick is accepted
//  every cycle while the result register is free or drains.
//  The result register is the only buffer; a stalled master side holds it and
//  drops o_s_tready until the result is taken.
//  Reset is synchronous, active low, and leaves the bus idle with SCL, SDA
//  high and driven; ticks_per_us is 72 and ack_timeout 250 after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: req_type[2:0], tx_byte[10:3], send_ack[11], sda_in[12], zero pad
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,
    // tdata: scl_level[0], sda_level[1], sda_drive[2], busy_res[3],
    //        done_res[4], rx_byte[12:5], ack_error[13], zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [9:0]  i_cfg_wdata
);
    import i2cm_pkg::*;

    t_state      r_state, n_state;
    t_cfg        r_cfg;
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic        w_done;
    logic        w_accept;

    assign o_s_tready = ~r_out_valid | i_m_tready;
    assign w_accept   = i_s_tvalid & o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    i2cm_step u_step (
        .i_state    (r_state),
        .i_cfg      (r_cfg),
        .i_req      (i_s_tdata[2:0]),
        .i_tx_byte  (i_s_tdata[10:3]),
        .i_send_ack (i_s_tdata[11]),
        .i_sda_in   (i_s_tdata[12]),
        .o_state    (n_state),
        .o_done     (w_done)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_us <= TPU_W'(72);
            r_cfg.ack_timeout  <= TMO_W'(250);
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_TPU) begin
                r_cfg.ticks_per_us <= i_cfg_wdata;
            end else begin
                r_cfg.ack_timeout <= i_cfg_wdata[TMO_W-1:0];
            end
        end
    end

    // engine state: advance one tick per accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= PH_IDLE;
            r_state.delay_count <= '0;
            r_state.bit_index   <= '0;
            r_state.shift_data  <= '0;
            r_state.poll_count  <= '0;
            r_state.ack_choice  <= 1'b0;
            r_state.scl         <= 1'b1;
            r_state.sda         <= 1'b1;
            r_state.drive       <= 1'b1;
            r_state.error_flag  <= 1'b0;
            r_state.rx_hold     <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {2'b00, n_state.error_flag, n_state.rx_hold, w_done,
                           (n_state.phase != PH_IDLE), n_state.drive, n_state.sda,
                           n_state.scl};
        end
    end

    // a completed command leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_done) |=> (r_state.phase == PH_IDLE))
        else $error("engine not idle after command completion");

    // every timed phase has a running delay
    a_delay_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_IDLE || r_state.phase == PH_AK_POLL ||
         r_state.delay_count != '0))
        else $error("timed phase with zero delay");

    // bit counter never runs past one byte
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.bit_index <= 4'd8))
        else $error("bit index beyond eight");

    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_out_valid && !i_m_tready))
        else $error("input stalled without a pending result");

endmodule

`default_nettype wire

// ===== rtl/i2cm_step.sv =====
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state logic of the bit engine: one bus tick applied to the state.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_step (
    input  i2cm_pkg::t_state i_state,
    input  i2cm_pkg::t_cfg   i_cfg,
    input  logic [2:0]       i_req,
    input  logic [7:0]       i_tx_byte,
    input  logic             i_send_ack,
    input  logic             i_sda_in,
    output i2cm_pkg::t_state o_state,
    output logic             o_done
);
    import i2cm_pkg::*;

    logic [DLY_W-1:0]   d1, d2, d4;
    logic [PHASE_W-1:0] ph;
    logic [7:0]         sh;
    logic [3:0]         bi;

    assign d1 = unit_ticks(i_cfg.ticks_per_us, 2'd0);
    assign d2 = unit_ticks(i_cfg.ticks_per_us, 2'd1);
    assign d4 = unit_ticks(i_cfg.ticks_per_us, 2'd2);
    assign bi = i_state.bit_index + 4'd1;

    always_comb begin
        o_state = i_state;
        o_done  = 1'b0;
        ph      = i_state.phase;
        sh      = i_state.shift_data;

        if (i_state.phase == PH_IDLE) begin
            case (i_req)
                REQ_START: begin
                    o_state.drive = 1'b1; o_state.sda = 1'b1; o_state.scl = 1'b1;
                    o_state.phase = PH_ST_A; o_state.delay_count = d4;
                end
                REQ_STOP: begin
                    o_state.drive = 1'b1; o_state.scl = 1'b0; o_state.sda = 1'b0;
                    o_state.phase = PH_SP_A; o_state.delay_count = d4;
                end
                REQ_WRITE: begin
                    o_state.error_flag = 1'b0; o_state.shift_data = i_tx_byte;
                    o_state.bit_index = 4'd0; o_state.drive = 1'b1; o_state.scl = 1'b0;
                    o_state.phase = PH_WR_LEAD; o_state.delay_count = d2;
                end
                REQ_READ: begin
                    o_state.ack_choice = i_send_ack; o_state.shift_data = 8'h00;
                    o_state.bit_index = 4'd0; o_state.sda = 1'b1;
                    o_state.drive = 1'b0; o_state.scl = 1'b0;
                    o_state.phase = PH_RD_LOW; o_state.delay_count = d2;
                end
                default: ;
            endcase
        end else if (i_state.phase == PH_AK_POLL) begin
            if (!i_sda_in) begin
                o_state.scl = 1'b0;
                o_state.phase = PH_AK_END; o_state.delay_count = d1;
            end else if (i_state.poll_count >= i_cfg.ack_timeout) begin
                // no ACK in time: flag it and release the bus with a stop
                o_state.error_flag = 1'b1;
                o_state.drive = 1'b1; o_state.scl = 1'b0; o_state.sda = 1'b0;
                o_state.phase = PH_SP_A; o_state.delay_count = d4;
            end else if (i_state.poll_count != 8'hFF) begin
                o_state.poll_count = i_state.poll_count + 8'd1;
            end
        end else if (i_state.phase == PH_ST_C || i_state.phase == PH_SP_C ||
                     i_state.phase == PH_AK_END || i_state.phase == PH_AC_C) begin
            if (i_state.delay_count > DLY_W'(1)) begin
                o_state.delay_count = i_state.delay_count - DLY_W'(1);
            end else begin
                o_state.phase = PH_IDLE; o_state.delay_count = '0; o_done = 1'b1;
            end
        end else begin
            if (i_state.phase == PH_RD_SAMP) begin
                sh = {i_state.shift_data[6:0], i_sda_in};
                ph = PH_RD_HIGH;
            end
            o_state.shift_data = sh;
            o_state.phase      = ph;
            if (i_state.delay_count > DLY_W'(1)) begin
                o_state.delay_count = i_state.delay_count - DLY_W'(1);
            end else begin
                unique case (ph)
                    PH_ST_A: begin
                        o_state.sda = 1'b0; o_state.phase = PH_ST_B; o_state.delay_count = d4;
                    end
                    PH_ST_B: begin
                        o_state.scl = 1'b0; o_state.phase = PH_ST_C; o_state.delay_count = d1;
                    end
                    PH_SP_A: begin
                        o_state.scl = 1'b1; o_state.phase = PH_SP_B; o_state.delay_count = d4;
                    end
                    PH_SP_B: begin
                        o_state.sda = 1'b1; o_state.phase = PH_SP_C; o_state.delay_count = d4;
                    end
                    PH_WR_LEAD: begin
                        o_state.sda = sh[7]; o_state.shift_data = {sh[6:0], 1'b0};
                        o_state.phase = PH_WR_SETUP; o_state.delay_count = d2;
                    end
                    PH_WR_SETUP: begin
                        o_state.scl = 1'b1; o_state.phase = PH_WR_HIGH;
                        o_state.delay_count = d2;
                    end
                    PH_WR_HIGH: begin
                        o_state.scl = 1'b0; o_state.bit_index = bi;
                        if (bi < 4'd8) begin
                            o_state.phase = PH_WR_LEAD; o_state.delay_count = d2;
                        end else begin
                            o_state.drive = 1'b0; o_state.sda = 1'b1;
                            o_state.phase = PH_AK_REL; o_state.delay_count = d1;
                        end
                    end
                    PH_AK_REL: begin
                        o_state.scl = 1'b1; o_state.poll_count = 8'h00;
                        o_state.phase = PH_AK_HIGH; o_state.delay_count = d1;
                    end
                    PH_AK_HIGH: begin
                        o_state.phase = PH_AK_POLL; o_state.delay_count = '0;
                    end
                    PH_RD_LOW: begin
                        o_state.scl = 1'b1; o_state.phase = PH_RD_SAMP;
                        o_state.delay_count = d1;
                    end
                    PH_RD_HIGH: begin
                        o_state.scl = 1'b0; o_state.bit_index = bi;
                        if (bi < 4'd8) begin
                            o_state.phase = PH_RD_LOW; o_state.delay_count = d2;
                        end else begin
                            o_state.rx_hold = sh; o_state.drive = 1'b1;
                            o_state.sda = ~i_state.ack_choice;
                            o_state.phase = PH_AC_A; o_state.delay_count = d2;
                        end
                    end
                    PH_AC_A: begin
                        o_state.scl = 1'b1; o_state.phase = PH_AC_B; o_state.delay_count = d2;
                    end
                    PH_AC_B: begin
                        o_state.scl = 1'b0; o_state.phase = PH_AC_C; o_state.delay_count = d1;
                    end
                    default: begin
                        o_state.phase = PH_IDLE; o_state.delay_count = '0; o_done = 1'b1;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire
